/* src/stsc_pkg.sv */
// ----------------------------------------------------------------------------
// Sphere-trace step controller package
// Widths, types, status and operation codes shared by the controller and its
// channel interfaces.
// ----------------------------------------------------------------------------
package stsc_pkg;

   localparam int unsigned DIST_W      = 32;
   localparam int unsigned PARAM_W     = 31;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned STEP_W      = 8;
   localparam int unsigned MAX_STEPS   = 192;
   localparam int unsigned DELAY_DEPTH = 3;
   localparam int unsigned SLOT_W      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

   typedef logic [PARAM_W-1:0]         param_type;
   typedef logic signed [DIST_W-1:0]   dist_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef dist_type [DELAY_DEPTH-1:0] window_type;

   // The largest positive distance stands for "far".
   localparam dist_type  FAR_DIST   = {1'b0, {(DIST_W-1){1'b1}}};
   localparam param_type PARAM_MAX  = '1;
   localparam param_type THR_RESET  = PARAM_W'(32768);
   localparam step_type  STEP_LIMIT = STEP_W'(MAX_STEPS);
   localparam step_type  STEP_SAT   = '1;
   localparam slot_type  SLOT_LAST  = SLOT_W'(DELAY_DEPTH - 1);

   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam status_type ST_QUERY     = 2'd0;
   localparam status_type ST_HIT       = 2'd1;
   localparam status_type ST_MISS      = 2'd2;
   localparam status_type ST_EXHAUSTED = 2'd3;

endpackage

/* src/stsc_req_if.sv */
// ----------------------------------------------------------------------------
// Sphere-trace request channel
// Valid/ready channel carrying a start word or a distance sample word.
// ----------------------------------------------------------------------------
interface stsc_req_if;
   import stsc_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   param_type t_min;
   param_type ray_length;
   dist_type  sample_distance;

   modport source (output valid, op, t_min, ray_length, sample_distance, input ready);
   modport sink   (input valid, op, t_min, ray_length, sample_distance, output ready);

endinterface

/* src/stsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sphere-trace response channel
// Valid/ready channel carrying one status word per request word.
// ----------------------------------------------------------------------------
interface stsc_rsp_if;
   import stsc_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   param_type  ray_param;
   dist_type   closest_approach;

   modport source (output valid, status, ray_param, closest_approach, input ready);
   modport sink   (input valid, status, ray_param, closest_approach, output ready);

endinterface

/* src/sphere_trace_step_controller.sv */
// ----------------------------------------------------------------------------
// Sphere-trace step controller
// Marches one ray: start words set up the ray, distance samples advance it.
// ----------------------------------------------------------------------------
// The controller takes one word per clock when not stalled and returns
// exactly one response word for each: the request is captured in an input
// register, the hit test, window fold, step add and limit compares are done
// in one pass, and the answer lands in the response register. Both
// registers may hold while the response side stalls, so up to two words are
// in flight. A start word (op 0) returns a query for the first t, or a miss
// at once if that t already lies beyond the ray length limit. Each sample
// word returns a hit, a query for the next t, a miss past the ray length
// limit or exhaustion after the step limit. A sample with no ray in progress
// returns a miss and changes nothing. The surface threshold register may only
// be written while no word is in flight.
module sphere_trace_step_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  stsc_pkg::param_type csr_wr_data,
   stsc_req_if.sink           req_chan,
   stsc_rsp_if.source         rsp_chan
);
   import stsc_pkg::*;

   // Configuration.
   param_type  thr_ff, thr_in;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic       op_ff;
   param_type  t_min_ff;
   param_type  max_dist_ff;
   dist_type   sample_ff;

   // Ray state.
   param_type  ray_t_ff, ray_t_in;
   param_type  limit_ff, limit_in;
   window_type window_ff, window_in;
   slot_type   slot_ff, slot_in;
   dist_type   nearest_ff, nearest_in;
   step_type   step_ff, step_in;
   logic       active_ff, active_in;

   // Response register.
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   param_type  param_ff;
   dist_type   near_out_ff;

   logic       req_fire;
   logic       advance;
   param_type  start_t;
   logic       below_thr;
   logic [PARAM_W:0] t_sum;
   param_type  t_next;
   step_type   step_next;
   window_type window_new;
   dist_type   fold_one;
   dist_type   fold_all;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign thr_in      = csr_wr_en ? csr_wr_data : thr_ff;
   assign in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // Datapath pieces for both kinds of word.
   assign start_t   = (t_min_ff > thr_ff) ? t_min_ff : thr_ff;
   assign below_thr = sample_ff < $signed({1'b0, thr_ff});
   // On the step path the sample is at least the threshold, so it is non-negative.
   assign t_sum     = {1'b0, ray_t_ff} + {1'b0, sample_ff[PARAM_W-1:0]};
   assign t_next    = t_sum[PARAM_W] ? PARAM_MAX : t_sum[PARAM_W-1:0];
   assign step_next = (step_ff == STEP_SAT) ? STEP_SAT : step_ff + step_type'(1);
   assign fold_one  = (window_ff[slot_ff] < nearest_ff) ? window_ff[slot_ff] : nearest_ff;

   always_comb begin
      window_new          = window_ff;
      window_new[slot_ff] = sample_ff;
   end

   // The oldest entry is already in fold_one; folding the whole updated window
   // on top of it gives the minimum over every sample of the ray.
   always_comb begin
      fold_all = fold_one;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
         if (window_new[i] < fold_all) begin
            fold_all = window_new[i];
         end
      end
   end

   always_comb begin
      ray_t_in   = ray_t_ff;
      limit_in   = limit_ff;
      window_in  = window_ff;
      slot_in    = slot_ff;
      nearest_in = nearest_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      status_in  = ST_MISS;
      if (advance) begin
         unique case (op_ff)
            OP_START: begin
               ray_t_in   = start_t;
               limit_in   = max_dist_ff;
               window_in  = {DELAY_DEPTH{FAR_DIST}};
               slot_in    = '0;
               nearest_in = FAR_DIST;
               step_in    = '0;
               if (start_t > max_dist_ff) begin
                  active_in = 1'b0;
                  status_in = ST_MISS;
               end else begin
                  active_in = 1'b1;
                  status_in = ST_QUERY;
               end
            end
            OP_SAMPLE: begin
               priority if (!active_ff) begin
                  status_in = ST_MISS;
               end else if (below_thr) begin
                  active_in = 1'b0;
                  status_in = ST_HIT;
               end else begin
                  window_in = window_new;
                  slot_in   = (slot_ff == SLOT_LAST) ? '0 : slot_ff + slot_type'(1);
                  ray_t_in  = t_next;
                  step_in   = step_next;
                  priority if (step_next >= STEP_LIMIT) begin
                     nearest_in = fold_all;
                     active_in  = 1'b0;
                     status_in  = ST_EXHAUSTED;
                  end else if (t_next > limit_ff) begin
                     nearest_in = fold_all;
                     active_in  = 1'b0;
                     status_in  = ST_MISS;
                  end else begin
                     nearest_in = fold_one;
                     status_in  = ST_QUERY;
                  end
               end
            end
            default: begin
               status_in = ST_MISS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ray_t_ff     <= '0;
         limit_ff     <= '0;
         window_ff    <= {DELAY_DEPTH{FAR_DIST}};
         slot_ff      <= '0;
         nearest_ff   <= FAR_DIST;
         step_ff      <= '0;
         active_ff    <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ray_t_ff     <= ray_t_in;
         limit_ff     <= limit_in;
         window_ff    <= window_in;
         slot_ff      <= slot_in;
         nearest_ff   <= nearest_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_chan.op;
         t_min_ff    <= req_chan.t_min;
         max_dist_ff <= req_chan.ray_length;
         sample_ff   <= req_chan.sample_distance;
      end
      if (advance) begin
         status_ff   <= status_in;
         param_ff    <= ray_t_in;
         near_out_ff <= nearest_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.ray_param        = param_ff;
   assign rsp_chan.closest_approach = near_out_ff;

   // The step counter is cleared on start and stops advancing at the limit.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LIMIT)
      else $error("step counter beyond the step limit");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("window slot out of range");

   // A query leaves the ray in progress; every other answer ends it.
   a_query_active: assert property (@(posedge clock) disable iff (reset)
      (advance && status_in == ST_QUERY) |=> active_ff)
      else $error("query issued without a ray in progress");

   a_end_inactive: assert property (@(posedge clock) disable iff (reset)
      (advance && status_in != ST_QUERY) |=> !active_ff)
      else $error("ray still in progress after a final answer");

   // A word held in the input register must not be lost while the output stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(op_ff) && $stable(sample_ff)))
      else $error("stalled input word changed");

endmodule

/* tb/sphere_trace_step_controller_tb.sv */
// ----------------------------------------------------------------------------
// Sphere-trace step controller testbench
// Sends start and distance-sample words through the request channel, works
// out each response word from its own model of the ray march, and checks the
// response channel word by word. Several surface thresholds are used, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module sphere_trace_step_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stsc_pkg::*;

   localparam int unsigned IDLE_PCT       = 24;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned MAX_REPORTS    = 200;

   typedef struct packed {
      status_type status;
      param_type  ray_param;
      dist_type   closest_approach;
   } response_word;

   class ray_march_tracker;
      param_type    threshold;
      param_type    ray_t;
      param_type    ray_limit;
      dist_type     window [DELAY_DEPTH];
      int unsigned  slot;
      dist_type     nearest;
      step_type     steps;
      bit           active;
      response_word pending[$];
      int unsigned  errors;

      function new();
         threshold = THR_RESET;
         ray_t     = '0;
         ray_limit = '0;
         clear_window();
         nearest   = FAR_DIST;
         steps     = '0;
         active    = 1'b0;
         errors    = 0;
      endfunction

      function void clear_window();
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            window[i] = FAR_DIST;
         end
         slot = 0;
      endfunction

      function void fold_window();
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            if (window[i] < nearest) begin
               nearest = window[i];
            end
         end
      endfunction

      function void report(string what);
         errors++;
         // Beyond this many the log says nothing new, so only the count goes on.
         if (errors <= MAX_REPORTS) begin
            $display("%0t ERROR: %s", $time, what);
         end
      endfunction

      function void note_request(logic op, param_type t_min, param_type max_dist,
                                 dist_type d);
         logic [PARAM_W:0] next_t;
         status_type       status;
         response_word     want_word;
         if (op == OP_START) begin
            ray_limit = max_dist;
            ray_t     = (t_min > threshold) ? t_min : threshold;
            clear_window();
            nearest   = FAR_DIST;
            steps     = '0;
            if (ray_t > ray_limit) begin
               fold_window();
               active = 1'b0;
               status = ST_MISS;
            end else begin
               active = 1'b1;
               status = ST_QUERY;
            end
         end else if (!active) begin
            status = ST_MISS;
         end else if (d < $signed({1'b0, threshold})) begin
            // On a hit the delayed samples are deliberately left out.
            active = 1'b0;
            status = ST_HIT;
         end else begin
            if (window[slot] < nearest) begin
               nearest = window[slot];
            end
            window[slot] = d;
            slot = (slot == DELAY_DEPTH - 1) ? 0 : slot + 1;
            // The sample is known to be non-negative here, so its low bits are its value.
            next_t = {1'b0, ray_t} + {1'b0, d[PARAM_W-1:0]};
            ray_t  = next_t[PARAM_W] ? PARAM_MAX : next_t[PARAM_W-1:0];
            if (steps != STEP_SAT) begin
               steps++;
            end
            if (steps >= STEP_LIMIT) begin
               fold_window();
               active = 1'b0;
               status = ST_EXHAUSTED;
            end else if (ray_t > ray_limit) begin
               fold_window();
               active = 1'b0;
               status = ST_MISS;
            end else begin
               status = ST_QUERY;
            end
         end
         want_word = '{status, ray_t, nearest};
         pending.insert(pending.size(), want_word);
      endfunction

      function void check_response(response_word got);
         response_word want;
         if (pending.size() == 0) begin
            report($sformatf("response word with none outstanding: status %0d t %h near %h",
                             got.status, got.ray_param, got.closest_approach));
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         end
         if (got.ray_param !== want.ray_param) begin
            report($sformatf("ray_param %h, expected %h", got.ray_param, want.ray_param));
         end
         if (got.closest_approach !== want.closest_approach) begin
            report($sformatf("closest_approach %h, expected %h",
                             got.closest_approach, want.closest_approach));
         end
      endfunction

      function void finish_check();
         if (pending.size() != 0) begin
            report($sformatf("%0d response words never arrived", pending.size()));
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   param_type  csr_wr_data;

   stsc_req_if req_bus ();
   stsc_rsp_if rsp_bus ();

   ray_march_tracker tracker;
   bit               quiet_spell;
   int unsigned      stall_cycles;

   sphere_trace_step_controller dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= quiet_spell || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Both channels are sampled here; the watchdog counts edges with no word moved.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_request(req_bus.op, req_bus.t_min, req_bus.ray_length,
                                 req_bus.sample_distance);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_response('{rsp_bus.status, rsp_bus.ray_param,
                                     rsp_bus.closest_approach});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("sphere_trace_step_controller test failed");
               $finish;
            end
         end
      end
   end

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_word(logic op, param_type t_min, param_type max_dist, dist_type d);
      req_bus.valid           <= 1'b1;
      req_bus.op              <= op;
      req_bus.t_min           <= t_min;
      req_bus.ray_length      <= max_dist;
      req_bus.sample_distance <= d;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_sample(dist_type d);
      send_word(OP_SAMPLE, param_type'($urandom), param_type'($urandom), d);
   endtask

   task automatic idle_sender();
      while (!quiet_spell && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_threshold(param_type value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.threshold = value;
   endtask

   function automatic param_type pick_t_min();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         return '0;
      end else if (pick < 13) begin
         return param_type'($urandom_range(0, 'h3FFFF));
      end else if (pick < 18) begin
         return param_type'($urandom);
      end
      return PARAM_MAX;
   endfunction

   // Long rays take only steps of at most three above the threshold so that the step limit is reached.
   function automatic dist_type pick_sample(bit long_ray);
      param_type         thr;
      longint unsigned   room;
      longint unsigned   stride;
      longint unsigned   value;
      int unsigned       pick;
      thr  = tracker.threshold;
      room = (tracker.ray_limit > tracker.ray_t) ? tracker.ray_limit - tracker.ray_t : 0;
      pick = $urandom_range(0, 99);
      if (long_ray) begin
         value = thr + $urandom_range(0, 3);
      end else if (pick < 6) begin
         if (thr == 0) begin
            return {1'b1, 31'($urandom)};
         end
         return dist_type'($urandom_range(0, thr - 1));
      end else if (pick < 10) begin
         return {1'b1, 31'($urandom)};
      end else if (pick < 20) begin
         value = thr;
      end else if (pick < 65) begin
         stride = room / $urandom_range(2, 30);
         value  = ((stride > thr) ? stride : thr) + $urandom_range(0, 15);
      end else if (pick < 88) begin
         value = thr + $urandom_range(0, 255);
      end else if (pick < 95) begin
         value = $urandom & 32'h7FFF_FFFF;
      end else begin
         value = PARAM_MAX;
      end
      if (value > PARAM_MAX) begin
         value = PARAM_MAX;
      end
      return {1'b0, value[PARAM_W-1:0]};
   endfunction

   task automatic launch_ray(bit long_ray);
      param_type       t_min;
      param_type       t_first;
      param_type       max_dist;
      longint unsigned reach;
      int unsigned     pick;
      t_min   = pick_t_min();
      t_first = (t_min > tracker.threshold) ? t_min : tracker.threshold;
      pick    = $urandom_range(0, 99);
      if (long_ray || pick >= 92) begin
         max_dist = PARAM_MAX;
      end else if (pick < 70) begin
         reach    = t_first + $urandom_range(0, 'h01FF_FFFF);
         max_dist = (reach > PARAM_MAX) ? PARAM_MAX : param_type'(reach);
      end else if (pick < 85) begin
         max_dist = param_type'($urandom);
      end else begin
         max_dist = '0;
      end
      send_word(OP_START, t_min, max_dist, dist_type'($urandom));
   endtask

   task automatic run_phase(int unsigned words, bit calm, bit open_long);
      int unsigned sent;
      int unsigned roll;
      bit          long_ray;
      sent        = 0;
      quiet_spell = calm;
      while (sent < words) begin
         long_ray = open_long && (sent == 0);
         idle_sender();
         launch_ray(long_ray);
         sent++;
         while (tracker.active) begin
            idle_sender();
            roll = $urandom_range(0, 99);
            // Now and then the ray is abandoned by a fresh start word.
            if (!long_ray && roll < 2) begin
               break;
            end
            if (roll == 2) begin
               drain();
            end
            send_sample(pick_sample(long_ray));
            sent++;
         end
         if ($urandom_range(0, 99) < 8) begin
            idle_sender();
            send_sample(pick_sample(1'b0));
            sent++;
         end
      end
      quiet_spell = 1'b0;
   endtask

   initial begin
      tracker                 = new();
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_wr_data             = '0;
      req_bus.valid           = 1'b0;
      req_bus.op              = OP_START;
      req_bus.t_min           = '0;
      req_bus.ray_length      = '0;
      req_bus.sample_distance = '0;
      quiet_spell             = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset threshold of half a unit.
      send_sample(32'sd1000);
      send_word(OP_START, '0, PARAM_MAX, '0);
      send_sample(dist_type'(THR_RESET) - 1);
      send_sample(32'sd5);
      send_word(OP_START, PARAM_MAX, PARAM_MAX, FAR_DIST);
      send_sample(dist_type'(THR_RESET));
      send_sample(FAR_DIST);
      send_sample({1'b1, 31'd0});
      send_word(OP_START, 31'h0010_0000, 31'h000F_FFFF, '0);
      send_word(OP_START, '0, '0, '0);
      send_word(OP_START, '0, THR_RESET, '0);
      send_sample(dist_type'(THR_RESET));
      send_word(OP_START, '0, 31'h0040_0000, '0);
      send_sample(32'sh0001_0000);
      send_sample(dist_type'(THR_RESET));
      send_sample(32'sh0002_0000);
      send_sample(32'sh0000_9000);
      send_sample(32'sh0001_8000);
      send_sample(-32'sd1);
      send_word(OP_START, '0, PARAM_MAX, '0);
      send_sample(FAR_DIST);
      send_sample(32'sh4000_0000);
      send_word(OP_START, 31'h0000_1234, PARAM_MAX, '0);
      send_sample('0);

      run_phase(150, 1'b0, 1'b0);
      write_threshold(31'd1);
      run_phase(150, 1'b1, 1'b1);
      write_threshold('0);
      run_phase(120, 1'b0, 1'b1);
      write_threshold(PARAM_MAX);
      run_phase(40, 1'b0, 1'b0);
      write_threshold(param_type'($urandom_range(1, 'h3F_FFFF)));
      run_phase(150, 1'b0, 1'b0);
      write_threshold(param_type'($urandom_range(1, 'h7FFF_FFFF)));
      run_phase(60, 1'b0, 1'b0);
      write_threshold(THR_RESET);
      run_phase(100, 1'b0, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      tracker.finish_check();
      if (tracker.errors == 0) begin
         $display("sphere_trace_step_controller test passed");
      end else begin
         $display("sphere_trace_step_controller test failed");
      end
      $finish;
   end

endmodule
